FILE: sv/lnss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_pkg
// Shared types and constants of the nearest-sector speed adjust block.
// ----------------------------------------------------------------------------
package lnss_pkg;

  // Field widths.
  localparam int ANGLE_Q_W = 16;
  localparam int DIST_Q_W  = 32;
  localparam int QUAL_W    = 8;
  localparam int DIR_W     = 3;
  localparam int SPEED_W   = 8;
  localparam int THR_W     = 16;
  localparam int NDIST_W   = 16;
  localparam int ANGLE_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 16;

  localparam int QUALITY_SHIFT = 2;

  // angle = (angle_q14 * 90) >> 14
  localparam int ANGLE_MULT = 90;
  localparam int ANGLE_FRAC = 14;
  localparam int PROD_W     = ANGLE_Q_W + 7;

  // Sector limits in degrees.
  localparam logic [ANGLE_W-1:0] FRONT_HI = 9'd45;
  localparam logic [ANGLE_W-1:0] RIGHT_HI = 9'd135;
  localparam logic [ANGLE_W-1:0] REAR_HI  = 9'd225;
  localparam logic [ANGLE_W-1:0] FRONT_LO = 9'd315;

  // Reset values.
  localparam logic [THR_W-1:0]   THR_RST    = 16'd700;
  localparam logic [SPEED_W-1:0] NORMAL_RST = 8'd80;
  localparam logic [SPEED_W-1:0] MAX_RST    = 8'd150;
  localparam logic [SPEED_W-1:0] SPEED_RST  = 8'd80;

  // Scan summary queue.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_FRONT = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_REAR  = 3'd3,
    DIR_LEFT  = 3'd4
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_NORMAL    = 2'd1,
    CFG_MAX       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [SPEED_W-1:0] cruise_spd;
    logic [SPEED_W-1:0] top_spd;
  } cfg_t;

  // What one finished scan leaves for the speed logic.
  typedef struct packed {
    logic               found;
    logic [NDIST_W-1:0] nearest_mm;
    logic [ANGLE_W-1:0] angle;
  } scan_sum_t;

endpackage
`default_nettype wire

FILE: sv/lnss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_in_if / lnss_out_if
// Valid/ready channels for measurement nodes and speed results.
// ----------------------------------------------------------------------------
interface lnss_in_if import lnss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ANGLE_Q_W-1:0] angle_q14;
  logic [DIST_Q_W-1:0]  dist_q2;
  logic [QUAL_W-1:0]    quality;
  logic                 last_of_scan;

  modport source (output valid, angle_q14, dist_q2, quality, last_of_scan,
                  input ready);
  modport sink   (input valid, angle_q14, dist_q2, quality, last_of_scan,
                  output ready);
endinterface

interface lnss_out_if import lnss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIR_W-1:0]   direction;
  logic [SPEED_W-1:0] speed_out;

  modport source (output valid, direction, speed_out, input ready);
  modport sink   (input valid, direction, speed_out, output ready);
endinterface
`default_nettype wire

FILE: sv/lnss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_front
// Accepts nodes, qualifies them and tracks the nearest one of each scan.
// ----------------------------------------------------------------------------
module lnss_front import lnss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lnss_in_if.sink    in_ch,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output scan_sum_t  push_data
);

  logic                  found_r, found_nxt;
  logic [NDIST_W-1:0]    ndist_r, ndist_nxt;
  logic [ANGLE_W-1:0]    nangle_r, nangle_nxt;

  logic [PROD_W-1:0]     prod;
  logic [ANGLE_W-1:0]    angle;
  logic [DIST_Q_W-3:0]   node_mm;
  logic [QUAL_W-1:0]     qual;
  logic                  cand;
  logic                  better;
  logic                  accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign prod    = PROD_W'(in_ch.angle_q14) * PROD_W'(ANGLE_MULT);
  assign angle   = prod[ANGLE_FRAC +: ANGLE_W];
  assign node_mm = in_ch.dist_q2[DIST_Q_W-1:2];
  assign qual    = in_ch.quality >> QUALITY_SHIFT;

  // A candidate is below the threshold, so its distance fits the 16-bit slot.
  assign cand   = (node_mm < (DIST_Q_W-2)'(cfg.threshold)) && (node_mm != '0)
                  && (qual != '0);
  assign better = cand && (!found_r || (node_mm[NDIST_W-1:0] < ndist_r));

  always_comb begin
    found_nxt  = found_r;
    ndist_nxt  = ndist_r;
    nangle_nxt = nangle_r;
    push_data.found      = found_r;
    push_data.nearest_mm = ndist_r;
    push_data.angle      = nangle_r;
    if (better) begin
      push_data.found      = 1'b1;
      push_data.nearest_mm = node_mm[NDIST_W-1:0];
      push_data.angle      = angle;
    end
    push = accept && in_ch.last_of_scan;
    if (accept) begin
      if (in_ch.last_of_scan) begin
        found_nxt = 1'b0;
      end else if (better) begin
        found_nxt  = 1'b1;
        ndist_nxt  = node_mm[NDIST_W-1:0];
        nangle_nxt = angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ndist_r  <= ndist_nxt;
    nangle_r <= nangle_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/lnss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_queue
// Short queue of scan summaries between the node front end and speed logic.
// ----------------------------------------------------------------------------
module lnss_queue import lnss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  scan_sum_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output scan_sum_t head
);

  scan_sum_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QAW'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QAW'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("scan summary pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("scan summary popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: sv/lnss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_back
// Classifies each scan's nearest node and steps the speed; holds the result.
// ----------------------------------------------------------------------------
module lnss_back import lnss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  scan_sum_t q_head,
  output logic      pop,
  lnss_out_if.source out_ch
);

  logic               out_valid_r, out_valid_nxt;
  dir_t               dir_r, dir_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [NDIST_W-1:0] prev_front_r, prev_front_nxt;
  logic [NDIST_W-1:0] prev_rear_r, prev_rear_nxt;
  logic [SPEED_W-1:0] relaxed;
  dir_t               dir;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.direction = dir_r;
  assign out_ch.speed_out = speed_r;

  always_comb begin
    priority if (!q_head.found) begin
      dir = DIR_NONE;
    end else if (q_head.angle <= FRONT_HI || q_head.angle >= FRONT_LO) begin
      dir = DIR_FRONT;
    end else if (q_head.angle <= RIGHT_HI) begin
      dir = DIR_RIGHT;
    end else if (q_head.angle <= REAR_HI) begin
      dir = DIR_REAR;
    end else begin
      dir = DIR_LEFT;
    end
  end

  always_comb begin
    priority if (speed_r > cfg.cruise_spd) begin
      relaxed = speed_r - 1'b1;
    end else if (speed_r < cfg.cruise_spd) begin
      relaxed = speed_r + 1'b1;
    end else begin
      relaxed = speed_r;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    dir_nxt        = dir_r;
    speed_nxt      = speed_r;
    prev_front_nxt = prev_front_r;
    prev_rear_nxt  = prev_rear_r;
    if (pop) begin
      out_valid_nxt  = 1'b1;
      dir_nxt        = dir;
      prev_front_nxt = (dir == DIR_FRONT) ? q_head.nearest_mm : '0;
      prev_rear_nxt  = (dir == DIR_REAR) ? q_head.nearest_mm : '0;
      unique case (dir)
        DIR_FRONT: begin
          // Without an earlier front distance the speed holds.
          if (prev_front_r != '0) begin
            if (q_head.nearest_mm < prev_front_r) begin
              speed_nxt = (speed_r != '0) ? speed_r - 1'b1 : speed_r;
            end else begin
              speed_nxt = relaxed;
            end
          end
        end
        DIR_REAR: begin
          if (prev_rear_r != '0) begin
            if (q_head.nearest_mm < prev_rear_r) begin
              speed_nxt = (speed_r < cfg.top_spd) ? speed_r + 1'b1 : speed_r;
            end else begin
              speed_nxt = relaxed;
            end
          end
        end
        default: begin
          speed_nxt = relaxed;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      dir_r        <= DIR_NONE;
      speed_r      <= SPEED_RST;
      prev_front_r <= '0;
      prev_rear_r  <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      dir_r        <= dir_nxt;
      speed_r      <= speed_nxt;
      prev_front_r <= prev_front_nxt;
      prev_rear_r  <= prev_rear_nxt;
    end
  end

`ifndef SYNTHESIS
  a_speed_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (speed_r == $past(speed_r)) || (speed_r == $past(speed_r) + 8'd1)
            || (speed_r == $past(speed_r) - 8'd1))
    else $error("speed moved by more than one step in a scan");

  a_none_clears_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_head.found) |=> (prev_front_r == '0) && (prev_rear_r == '0))
    else $error("previous distances kept after an empty scan");
`endif

endmodule
`default_nettype wire

FILE: sv/lidar_nearest_sector_speed_adjust_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_nearest_sector_speed_adjust_unit
// Nearest-obstacle sector classifier with one-step speed adjustment.
//
// Nodes of a scan arrive on in_ch in ascending angle order, one beat each;
// the beat with last_of_scan set closes the scan. Each closing beat yields
// one beat on out_ch with the sector of the nearest qualifying node and the
// speed after this scan; other beats yield nothing.
// One node is accepted per cycle while the queue is not full. A closing
// beat is written to a two-entry summary queue and, when out_ch is free,
// its result passes from there into the output register that drives out_ch.
// The speed logic retires one scan per cycle from the queue, while out_ch
// accepts, into a single output register; while out_ch stalls, the queue
// fills and in_ch drops ready only once two summaries wait.
// cfg_we writes cfg_wdata to register cfg_index (0 threshold, 1 normal
// speed, 2 max speed); write only while the block is idle.
// Synchronous reset restores the registers to 700, 80 and 150, the speed
// to 80, and clears the queue, the scan state and the previous distances.
// ----------------------------------------------------------------------------
module lidar_nearest_sector_speed_adjust_unit import lnss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lnss_in_if.sink              in_ch,
  lnss_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  logic      q_full;
  logic      q_valid;
  logic      push;
  logic      pop;
  scan_sum_t push_data;
  scan_sum_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: cfg_nxt.threshold  = cfg_wdata[THR_W-1:0];
        CFG_NORMAL:    cfg_nxt.cruise_spd = cfg_wdata[SPEED_W-1:0];
        CFG_MAX:       cfg_nxt.top_spd    = cfg_wdata[SPEED_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= THR_RST;
      cfg_r.cruise_spd <= NORMAL_RST;
      cfg_r.top_spd    <= MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lnss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  lnss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  lnss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
